FILE: design/sync_word_length_prefixed_deframer_core_macros.svh
// ----------------------------------------------------------------------------
// Deframer assertion macros
// Clocked, reset-gated property wrappers shared by the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef SYNC_WORD_LENGTH_PREFIXED_DEFRAMER_CORE_MACROS_SVH
`define SYNC_WORD_LENGTH_PREFIXED_DEFRAMER_CORE_MACROS_SVH

// same-cycle implication
`define SWLD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// next-cycle implication
`define SWLD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

FILE: design/swld_pkg.sv
// ----------------------------------------------------------------------------
// swld_pkg
// Types and constants for the sync word, length prefixed deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swld_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_WORD     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_NAME      = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_SECRET    = 8'd3;

    localparam logic [31:0] SYNC_WORD_RST     = 32'h1234_5678;
    localparam logic [31:0] TIMEOUT_TICKS_RST = 32'd1024;
    localparam logic [7:0]  MAX_NAME_RST      = 8'd32;
    localparam logic [7:0]  MAX_SECRET_RST    = 8'd64;

    localparam logic ACTION_BYTE = 1'b0;
    localparam logic ACTION_TICK = 1'b1;

    localparam logic [1:0] KIND_NAME   = 2'd0;
    localparam logic [1:0] KIND_SECRET = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_SYNC    = 2'd1;
    localparam logic [1:0] ERR_TIMEOUT = 2'd2;
    localparam logic [1:0] ERR_LENGTH  = 2'd3;

    localparam logic [1:0] SYNC_LAST = 2'd3;

    typedef enum logic [4:0] {
        PH_IDLE       = 5'b00001,
        PH_NAME_LEN   = 5'b00010,
        PH_SECRET_LEN = 5'b00100,
        PH_NAME       = 5'b01000,
        PH_SECRET     = 5'b10000
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  sync_index;
        logic [7:0]  name_remaining;
        logic [7:0]  secret_remaining;
        logic [31:0] elapsed_ticks;
    } frame_state_t;

    typedef struct packed {
        logic [31:0] sync_word;
        logic [31:0] timeout_ticks;
        logic [7:0]  max_name_length;
        logic [7:0]  max_secret_length;
    } frame_cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload;
        logic       field_last;
        logic       frame_done;
        logic [1:0] error_code;
    } result_t;

    localparam frame_state_t STATE_IDLE = '{
        phase:            PH_IDLE,
        sync_index:       2'd0,
        name_remaining:   8'd0,
        secret_remaining: 8'd0,
        elapsed_ticks:    32'd0
    };

endpackage

FILE: design/swld_step.sv
// ----------------------------------------------------------------------------
// swld_step
// Next-state and result logic for one beat: sync hunt, length capture,
// payload tagging and tick timeout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swld_step (
    input  swld_pkg::frame_state_t state,
    input  swld_pkg::frame_cfg_t   cfg,
    input  logic                   action,
    input  logic [7:0]             byte_value,
    output swld_pkg::frame_state_t state_next,
    output logic                   res_valid,
    output swld_pkg::result_t      res
);
    import swld_pkg::*;

    frame_state_t cur;
    logic         phase_ok;
    logic [7:0]   want;
    logic [31:0]  elapsed_inc;
    logic [7:0]   name_dec;
    logic [7:0]   secret_dec;

    // unused phase codes fall back to idle
    assign phase_ok = (state.phase == PH_IDLE) || (state.phase == PH_NAME_LEN) ||
                      (state.phase == PH_SECRET_LEN) || (state.phase == PH_NAME) ||
                      (state.phase == PH_SECRET);
    assign cur = phase_ok ? state : STATE_IDLE;

    always_comb
    begin
        case (cur.sync_index)
            2'd0:    want = cfg.sync_word[31:24];
            2'd1:    want = cfg.sync_word[23:16];
            2'd2:    want = cfg.sync_word[15:8];
            default: want = cfg.sync_word[7:0];
        endcase
    end

    assign elapsed_inc = (&cur.elapsed_ticks) ? cur.elapsed_ticks : cur.elapsed_ticks + 32'd1;
    assign name_dec    = cur.name_remaining - 8'd1;
    assign secret_dec  = cur.secret_remaining - 8'd1;

    always_comb
    begin
        state_next = cur;
        res_valid  = 1'b0;
        res        = '{kind: KIND_ERROR, payload: 8'd0, field_last: 1'b0,
                       frame_done: 1'b0, error_code: ERR_NONE};

        if (action == ACTION_TICK)
        begin
            // ticks before any sync byte are not counted
            if (!(cur.phase == PH_IDLE && cur.sync_index == 2'd0))
            begin
                if (elapsed_inc >= cfg.timeout_ticks)
                begin
                    state_next     = STATE_IDLE;
                    res_valid      = 1'b1;
                    res.error_code = ERR_TIMEOUT;
                end
                else
                begin
                    state_next.elapsed_ticks = elapsed_inc;
                end
            end
        end
        else
        begin
            state_next.elapsed_ticks = 32'd0;
            case (cur.phase)
                PH_NAME_LEN:
                begin
                    if (byte_value > cfg.max_name_length)
                    begin
                        state_next     = STATE_IDLE;
                        res_valid      = 1'b1;
                        res.error_code = ERR_LENGTH;
                    end
                    else
                    begin
                        state_next.name_remaining = byte_value;
                        state_next.phase          = PH_SECRET_LEN;
                    end
                end
                PH_SECRET_LEN:
                begin
                    if (byte_value > cfg.max_secret_length)
                    begin
                        state_next     = STATE_IDLE;
                        res_valid      = 1'b1;
                        res.error_code = ERR_LENGTH;
                    end
                    else if (cur.name_remaining == 8'd0 && byte_value == 8'd0)
                    begin
                        state_next     = STATE_IDLE;
                        res_valid      = 1'b1;
                        res.kind       = KIND_EMPTY;
                        res.frame_done = 1'b1;
                    end
                    else
                    begin
                        state_next.secret_remaining = byte_value;
                        state_next.phase = (cur.name_remaining != 8'd0) ? PH_NAME : PH_SECRET;
                    end
                end
                PH_NAME:
                begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_NAME;
                    res.payload    = byte_value;
                    res.field_last = (name_dec == 8'd0);
                    res.frame_done = (name_dec == 8'd0) && (cur.secret_remaining == 8'd0);
                    state_next.name_remaining = name_dec;
                    if (res.frame_done)
                    begin
                        state_next = STATE_IDLE;
                    end
                    else if (res.field_last)
                    begin
                        state_next.phase = PH_SECRET;
                    end
                end
                PH_SECRET:
                begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_SECRET;
                    res.payload    = byte_value;
                    res.field_last = (secret_dec == 8'd0);
                    res.frame_done = (secret_dec == 8'd0);
                    state_next.secret_remaining = secret_dec;
                    if (res.frame_done)
                    begin
                        state_next = STATE_IDLE;
                    end
                end
                default:
                begin
                    // sync hunt
                    if (byte_value != want)
                    begin
                        state_next     = STATE_IDLE;
                        res_valid      = 1'b1;
                        res.error_code = ERR_SYNC;
                    end
                    else if (cur.sync_index == SYNC_LAST)
                    begin
                        state_next.sync_index = 2'd0;
                        state_next.phase      = PH_NAME_LEN;
                    end
                    else
                    begin
                        state_next.sync_index = cur.sync_index + 2'd1;
                    end
                end
            endcase
        end
    end

endmodule

FILE: design/sync_word_length_prefixed_deframer_core.sv
// Path: a beat goes to the input register, its result to the result register.
// Throughput: one beat per cycle unless a result waits on result_ready; the
//   state loop: one 32-bit increment/compare and an 8-bit decrement.
// Reset (rst_n low, async): frame state idle, pipeline empty, registers back
//   to sync word 0x12345678, timeout 1024, name max 32, secret max 64.
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// sync_word_length_prefixed_deframer_core
// Input register, per-beat frame logic and a result register with handshake.
// ----------------------------------------------------------------------------
`include "sync_word_length_prefixed_deframer_core_macros.svh"

module sync_word_length_prefixed_deframer_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  logic                             action,
    input  logic [7:0]                       byte_value,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic [1:0]                       kind,
    output logic [7:0]                       payload,
    output logic                             field_last,
    output logic                             frame_done,
    output logic [1:0]                       error_code,
    input  logic                             cfg_we,
    input  logic [swld_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [swld_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import swld_pkg::*;

    frame_cfg_t   cfg_reg;
    frame_state_t state_reg;
    frame_state_t state_next;
    logic         s1_valid_reg;
    logic         s1_action_reg;
    logic [7:0]   s1_byte_reg;
    logic         res_valid;
    result_t      res;
    logic         out_free;
    logic         s1_go;
    logic         result_valid_reg;
    logic         result_valid_next;
    result_t      result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_word         <= SYNC_WORD_RST;
            cfg_reg.timeout_ticks     <= TIMEOUT_TICKS_RST;
            cfg_reg.max_name_length   <= MAX_NAME_RST;
            cfg_reg.max_secret_length <= MAX_SECRET_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SYNC_WORD:     cfg_reg.sync_word         <= cfg_data;
                REG_TIMEOUT_TICKS: cfg_reg.timeout_ticks     <= cfg_data;
                REG_MAX_NAME:      cfg_reg.max_name_length   <= cfg_data[7:0];
                REG_MAX_SECRET:    cfg_reg.max_secret_length <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    swld_step u_step (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .action     (s1_action_reg),
        .byte_value (s1_byte_reg),
        .state_next (state_next),
        .res_valid  (res_valid),
        .res        (res)
    );

    // a beat with no result never waits on the output side
    assign out_free   = !result_valid_reg || result_ready;
    assign s1_go      = s1_valid_reg && (!res_valid || out_free);
    assign item_ready = !s1_valid_reg || s1_go;

    always_comb
    begin
        result_valid_next = result_valid_reg && !result_ready;
        if (s1_go && res_valid)
        begin
            result_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= STATE_IDLE;
        end
        else
        begin
            s1_valid_reg     <= item_valid || (s1_valid_reg && !s1_go);
            result_valid_reg <= result_valid_next;
            if (s1_go)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            s1_action_reg <= action;
            s1_byte_reg   <= byte_value;
        end
        if (s1_go && res_valid)
        begin
            result_reg <= res;
        end
    end

    assign result_valid = result_valid_reg;
    assign kind         = result_reg.kind;
    assign payload      = result_reg.payload;
    assign field_last   = result_reg.field_last;
    assign frame_done   = result_reg.frame_done;
    assign error_code   = result_reg.error_code;

    `SWLD_ASSERT_IMPL(a_phase_onehot, 1'b1, $onehot(state_reg.phase))
    `SWLD_ASSERT_IMPL(a_sync_only_idle, state_reg.sync_index != 2'd0,
        state_reg.phase == PH_IDLE)
    `SWLD_ASSERT_IMPL(a_error_shape, result_valid_reg && result_reg.kind == KIND_ERROR,
        !result_reg.frame_done && result_reg.error_code != ERR_NONE)
    `SWLD_ASSERT_IMPL(a_done_is_last, result_valid_reg && result_reg.frame_done &&
        result_reg.kind != KIND_EMPTY, result_reg.field_last)
    `SWLD_ASSERT_NEXT(a_done_goes_idle, s1_go && res_valid && res.frame_done,
        state_reg.phase == PH_IDLE)

endmodule
